// ===== design/round_robin_mailbox_scheduler_unit_assert.svh =====
// Assertion macros shared by the mailbox scheduler modules.
`ifndef ROUND_ROBIN_MAILBOX_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_MAILBOX_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RRMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RRMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RRMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RRMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/rrms_pkg.sv =====
// Shared constants, codes and control types of the mailbox scheduler.
`timescale 1ns / 1ps
package rrms_pkg;

	localparam int MAX_ACTORS_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MSG_WIDTH_DEF   = 32;

	localparam int OP_W     = 2;
	localparam int IDX_W    = 6;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int PEND_W   = 5;
	localparam int CFG_W    = 7;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

	localparam logic REG_ACTOR_COUNT = 1'b0;

	localparam logic [OP_W-1:0] OP_TELL     = 2'd0;
	localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DONE     = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IDLE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic accept;
		logic look;
		logic mod_init;
		logic mod_step;
		logic exec;
		logic msg;
	} rrms_cmd_t;

	typedef struct packed {
		logic in_dispatch;
		logic start_ok;
		logic mod_last;
		logic out_free;
		logic need_msg;
	} rrms_sts_t;

endpackage

// ===== design/rrms_req_if.sv =====
// Request channel: operation, actor and message word with valid/ready.
`timescale 1ns / 1ps
interface rrms_req_if;
	logic                       valid;
	logic                       ready;
	logic [rrms_pkg::OP_W-1:0]   operation;
	logic [rrms_pkg::IDX_W-1:0]  actor_index;
	logic [rrms_pkg::WORD_W-1:0] message_word;

	modport source (output valid, output operation, output actor_index, output message_word,
		input ready);
	modport sink (input valid, input operation, input actor_index, input message_word,
		output ready);
endinterface

// ===== design/rrms_rsp_if.sv =====
// Result channel: status, actor, message and pending count with valid/ready.
`timescale 1ns / 1ps
interface rrms_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rrms_pkg::STATUS_W-1:0] status;
	logic [rrms_pkg::IDX_W-1:0]    chosen_actor;
	logic [rrms_pkg::WORD_W-1:0]   dispatched_message;
	logic [rrms_pkg::PEND_W-1:0]   pending_after;

	modport source (output valid, output status, output chosen_actor,
		output dispatched_message, output pending_after, input ready);
	modport sink (input valid, input status, input chosen_actor,
		input dispatched_message, input pending_after, output ready);
endinterface

// ===== design/rrms_datapath.sv =====
// Datapath: mailbox memories, per-actor flags, round robin pick, start modulo unit, result register.
`timescale 1ns / 1ps
`include "round_robin_mailbox_scheduler_unit_assert.svh"
module rrms_datapath #(
	parameter int MAX_ACTORS  = rrms_pkg::MAX_ACTORS_DEF,
	parameter int QUEUE_DEPTH = rrms_pkg::QUEUE_DEPTH_DEF,
	parameter int MSG_WIDTH   = rrms_pkg::MSG_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrms_pkg::rrms_cmd_t           cmd,
	output rrms_pkg::rrms_sts_t           sts,
	input  logic [rrms_pkg::OP_W-1:0]     op_in,
	input  logic [rrms_pkg::IDX_W-1:0]    idx_in,
	input  logic [rrms_pkg::WORD_W-1:0]   word_in,
	input  logic                          cfg_we,
	input  logic [rrms_pkg::CFG_W-1:0]    cfg_wdata,
	output logic [rrms_pkg::CFG_W-1:0]    cfg_value,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [rrms_pkg::STATUS_W-1:0] rsp_status,
	output logic [rrms_pkg::IDX_W-1:0]    rsp_actor,
	output logic [rrms_pkg::WORD_W-1:0]   rsp_message,
	output logic [rrms_pkg::PEND_W-1:0]   rsp_pending
);

	localparam int OW    = rrms_pkg::OP_W;
	localparam int IW    = rrms_pkg::IDX_W;
	localparam int WW    = rrms_pkg::WORD_W;
	localparam int PDW   = rrms_pkg::PEND_W;
	localparam int FW    = rrms_pkg::CFG_W;
	localparam int AW    = $clog2(MAX_ACTORS);
	localparam int HW    = $clog2(QUEUE_DEPTH);
	localparam int PW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SW    = (MSG_WIDTH < WW) ? MSG_WIDTH : WW;
	localparam int CW    = $clog2(MAX_ACTORS + 1);
	localparam int KW    = (CW > FW) ? CW : FW;
	localparam int MW    = HW + PW;
	localparam int SLOTS = 1 << HW;
	localparam int DEPTH = MAX_ACTORS * SLOTS;
	localparam int TW    = $clog2(AW + 1);

	logic [FW-1:0]         cnt_cfg_q;
	logic [KW-1:0]         cfg_ext;
	logic [KW-1:0]         cnt_eff;

	logic [OW-1:0]         op_q;
	logic [IW-1:0]         idx_q;
	logic [SW-1:0]         word_q;
	logic [AW-1:0]         target_q;
	logic                  ok_q;

	logic [MW-1:0]         meta_mem [MAX_ACTORS];
	logic [MAX_ACTORS-1:0] meta_vld_q;
	logic [MW-1:0]         meta_rd_q;
	logic                  meta_rd_vld_q;
	logic [SW-1:0]         store_mem [DEPTH];
	logic [SW-1:0]         store_rd_q;

	logic [MAX_ACTORS-1:0] nonempty_q;
	logic [MAX_ACTORS-1:0] active_q;

	logic [AW-1:0]         last_q;
	logic [AW-1:0]         start_q;
	logic                  start_ok_q;
	logic [KW-1:0]         rem_q;
	logic [AW-1:0]         div_q;
	logic [TW-1:0]         step_q;
	logic [KW:0]           rem_sh;
	logic [KW-1:0]         rem_n;

	logic [MAX_ACTORS-1:0] range_mask;
	logic [MAX_ACTORS-1:0] hi_mask;
	logic [MAX_ACTORS-1:0] elig;
	logic [MAX_ACTORS-1:0] elig_hi;
	logic [AW-1:0]         pick;
	logic                  pick_found;

	logic [OW-1:0]         op_c;
	logic [IW-1:0]         idx_c;
	logic                  in_range_c;
	logic [AW-1:0]         target_c;
	logic                  ok_c;

	logic [HW-1:0]         head;
	logic [PW-1:0]         count;
	logic [PW-1:0]         cnt_inc;
	logic [PW-1:0]         cnt_dec;
	logic                  full;
	logic [PW:0]           tail_sum;
	logic [HW-1:0]         tail;
	logic [HW-1:0]         head_nx;
	logic                  push;
	logic                  pop;
	logic                  clr;

	logic                  out_vld_q;
	logic [rrms_pkg::STATUS_W-1:0] res_status;
	logic [IW-1:0]         res_actor;
	logic [PDW-1:0]        res_pending;

	function automatic logic [AW-1:0] low_index(input logic [MAX_ACTORS-1:0] v);
		logic [AW-1:0] r;
		r = '0;
		for (int i = MAX_ACTORS - 1; i >= 0; i--) begin
			if (v[i]) r = AW'(i);
		end
		return r;
	endfunction

	// count register; its effective value is clamped to the number of actors built
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_cfg_q <= rrms_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cnt_cfg_q <= cfg_wdata;
		end
	end

	assign cfg_value = cnt_cfg_q;
	assign cfg_ext   = KW'(cnt_cfg_q);
	assign cnt_eff   = (cfg_ext > KW'(MAX_ACTORS)) ? KW'(MAX_ACTORS) : cfg_ext;

	// round robin pick: first eligible at or above start, else first eligible overall
	always_comb begin
		for (int a = 0; a < MAX_ACTORS; a++) begin
			range_mask[a] = KW'(a) < cnt_eff;
			hi_mask[a]    = AW'(a) >= start_q;
		end
	end

	assign elig       = nonempty_q & ~active_q & range_mask;
	assign elig_hi    = elig & hi_mask;
	assign pick       = (|elig_hi) ? low_index(elig_hi) : low_index(elig);
	assign pick_found = |elig;

	assign op_c       = cmd.accept ? op_in : op_q;
	assign idx_c      = cmd.accept ? idx_in : idx_q;
	assign in_range_c = KW'(idx_c) < cnt_eff;
	assign target_c   = (op_c == rrms_pkg::OP_DISPATCH) ? pick : AW'(idx_c);
	assign ok_c       = (op_c == rrms_pkg::OP_DISPATCH) ? pick_found : in_range_c;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op_in;
			idx_q  <= idx_in;
			word_q <= SW'(word_in);
		end
		if (cmd.look) begin
			target_q <= target_c;
			ok_q     <= ok_c;
		end
	end

	// start position = last choice modulo count, restoring remainder one bit a cycle
	assign rem_sh = {rem_q, div_q[AW-1]};
	assign rem_n  = (rem_sh >= (KW+1)'(cnt_eff)) ? KW'(rem_sh - (KW+1)'(cnt_eff)) : KW'(rem_sh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			start_q    <= '0;
			start_ok_q <= 1'b1;
			rem_q      <= '0;
			div_q      <= '0;
			step_q     <= '0;
		end else begin
			if (cfg_we) begin
				start_ok_q <= 1'b0;
			end
			if (cmd.mod_init) begin
				rem_q  <= '0;
				div_q  <= last_q;
				step_q <= TW'(AW);
			end
			if (cmd.mod_step) begin
				rem_q  <= rem_n;
				div_q  <= div_q << 1;
				step_q <= step_q - TW'(1);
				if (step_q == TW'(1)) begin
					start_q    <= AW'(rem_n);
					start_ok_q <= 1'b1;
				end
			end
			if (pop) begin
				last_q     <= target_q;
				start_q    <= target_q;
				start_ok_q <= 1'b1;
			end
		end
	end

	// per-actor mailbox state
	assign head     = meta_rd_vld_q ? meta_rd_q[MW-1:PW] : '0;
	assign count    = meta_rd_vld_q ? meta_rd_q[PW-1:0] : '0;
	assign cnt_inc  = count + PW'(1);
	assign cnt_dec  = count - PW'(1);
	assign full     = count >= PW'(QUEUE_DEPTH);
	assign tail_sum = (PW+1)'(head) + (PW+1)'(count);
	assign tail     = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
		HW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
	assign head_nx  = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);

	assign push = cmd.exec && (op_q == rrms_pkg::OP_TELL) && ok_q && !full;
	assign pop  = cmd.exec && (op_q == rrms_pkg::OP_DISPATCH) && ok_q;
	assign clr  = cmd.exec && (op_q == rrms_pkg::OP_DONE) && ok_q;

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			meta_rd_q <= meta_mem[target_c];
		end
		if (push) begin
			meta_mem[target_q] <= {head, cnt_inc};
		end else if (pop) begin
			meta_mem[target_q] <= {head_nx, cnt_dec};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			meta_rd_vld_q <= meta_vld_q[target_c];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_mem[{target_q, tail}] <= word_q;
		end
		if (pop) begin
			store_rd_q <= store_mem[{target_q, head}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
			nonempty_q <= '0;
			active_q   <= '0;
		end else begin
			if (push) begin
				meta_vld_q[target_q] <= 1'b1;
				nonempty_q[target_q] <= 1'b1;
			end
			if (pop) begin
				nonempty_q[target_q] <= count != PW'(1);
				active_q[target_q]   <= 1'b1;
			end
			if (clr) begin
				active_q[target_q] <= 1'b0;
			end
		end
	end

	// result fields
	always_comb begin
		res_status  = rrms_pkg::ST_OK;
		res_actor   = idx_q;
		res_pending = '0;
		unique case (op_q)
			rrms_pkg::OP_TELL: begin
				if (!ok_q) begin
					res_status = rrms_pkg::ST_RANGE;
				end else if (full) begin
					res_status  = rrms_pkg::ST_FULL;
					res_pending = PDW'(count);
				end else begin
					res_pending = PDW'(cnt_inc);
				end
			end
			rrms_pkg::OP_DONE: begin
				if (!ok_q) begin
					res_status = rrms_pkg::ST_RANGE;
				end else begin
					res_pending = PDW'(count);
				end
			end
			rrms_pkg::OP_DISPATCH: begin
				if (ok_q) begin
					res_actor   = IW'(target_q);
					res_pending = PDW'(cnt_dec);
				end else begin
					res_status = rrms_pkg::ST_IDLE;
				end
			end
			default: begin
				res_status = rrms_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.exec) begin
			out_vld_q <= !pop;
		end else if (cmd.msg) begin
			out_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_status  <= res_status;
			rsp_actor   <= res_actor;
			rsp_message <= '0;
			rsp_pending <= res_pending;
		end else if (cmd.msg) begin
			rsp_message <= WW'(store_rd_q);
		end
	end

	assign rsp_valid = out_vld_q;

	assign sts.in_dispatch = op_in == rrms_pkg::OP_DISPATCH;
	assign sts.start_ok    = start_ok_q;
	assign sts.mod_last    = step_q == TW'(1);
	assign sts.out_free    = !out_vld_q || rsp_ready;
	assign sts.need_msg    = (op_q == rrms_pkg::OP_DISPATCH) && ok_q;

	`RRMS_ASSERT_IMP(a_msg_slot_free, clk, arst_n, cmd.msg, !out_vld_q, "message lands on a held result")
	`RRMS_ASSERT_NXT(a_pop_marks_active, clk, arst_n, pop, active_q[target_q], "popped actor not active")
	`RRMS_ASSERT_NXT(a_push_nonempty, clk, arst_n, push, nonempty_q[target_q], "pushed mailbox reads empty")

endmodule

// ===== design/rrms_ctrl.sv =====
// Controller: sequences accept, start modulo, pick, execute and message read.
`timescale 1ns / 1ps
`include "round_robin_mailbox_scheduler_unit_assert.svh"
module rrms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rrms_pkg::rrms_sts_t sts,
	output rrms_pkg::rrms_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_PICK,
		S_EXEC,
		S_MSG
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_n   = state_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (sts.in_dispatch && !sts.start_ok) begin
						cmd.mod_init = 1'b1;
						state_n      = S_MOD;
					end else begin
						cmd.look = 1'b1;
						state_n  = S_EXEC;
					end
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) state_n = S_PICK;
			end
			S_PICK: begin
				cmd.look = 1'b1;
				state_n  = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_n  = sts.need_msg ? S_MSG : S_IDLE;
				end
			end
			S_MSG: begin
				if (sts.out_free) begin
					cmd.msg = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	`RRMS_ASSERT_IMP(a_msg_after_exec, clk, arst_n, state_q == S_MSG, $past(state_q) == S_EXEC || $past(state_q) == S_MSG, "message read without execute")
	`RRMS_ASSERT_IMP(a_pick_after_mod, clk, arst_n, state_q == S_PICK, $past(state_q) == S_MOD, "pick without start modulo")
	`RRMS_ASSERT_NXT(a_exec_holds, clk, arst_n, state_q == S_EXEC && !sts.out_free, state_q == S_EXEC, "execute left while result blocked")

endmodule

// ===== design/round_robin_mailbox_scheduler_unit.sv =====
// Top level of the round robin mailbox scheduler: request/result channels and APB count register.
// Sequence: tell, done and unused requests are accepted and then executed; dispatch adds a message read.
// One request in flight: a new request is accepted only after the previous one has completed.
// The first dispatch after a count write first recomputes the start position (last choice modulo count).
// Reset (arst_n, async): clears control, flags and mailbox valid bits, sets the count to 1;
// the message store is not cleared.
`timescale 1ns / 1ps
module round_robin_mailbox_scheduler_unit #(
	parameter int MAX_ACTORS  = rrms_pkg::MAX_ACTORS_DEF,
	parameter int QUEUE_DEPTH = rrms_pkg::QUEUE_DEPTH_DEF,
	parameter int MSG_WIDTH   = rrms_pkg::MSG_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rrms_req_if.sink                     req,
	rrms_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrms_pkg::PADDR_W-1:0] paddr,
	input  logic [rrms_pkg::PDATA_W-1:0] pwdata,
	output logic [rrms_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	rrms_pkg::rrms_cmd_t           cmd;
	rrms_pkg::rrms_sts_t           sts;
	logic                          cfg_we;
	logic [rrms_pkg::CFG_W-1:0]    cfg_value;
	logic                          reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[rrms_pkg::PADDR_W-1] == rrms_pkg::REG_ACTOR_COUNT;
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? rrms_pkg::PDATA_W'(cfg_value) : '0;

	rrms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrms_datapath #(
		.MAX_ACTORS  (MAX_ACTORS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MSG_WIDTH   (MSG_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op_in       (req.operation),
		.idx_in      (req.actor_index),
		.word_in     (req.message_word),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[rrms_pkg::CFG_W-1:0]),
		.cfg_value   (cfg_value),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_status  (rsp.status),
		.rsp_actor   (rsp.chosen_actor),
		.rsp_message (rsp.dispatched_message),
		.rsp_pending (rsp.pending_after)
	);

endmodule
